@@ hw/rtl/nwbb_pkg.sv @@
// ----------------------------------------------------------------------------
// nwbb_pkg
// Shared constants for the foreground bounding box block: register map,
// field widths and the fixed-point luma coefficients.
// ----------------------------------------------------------------------------
package nwbb_pkg;

    // Register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_CANVAS_WIDTH    = 2'd0,
        REG_CANVAS_HEIGHT   = 2'd1,
        REG_WHITE_THRESHOLD = 2'd2,
        REG_PAD_PIXELS      = 2'd3
    } t_reg_idx;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int CFG_SIZE_W = 13;
    localparam int CHAN_W     = 8;
    localparam int PAD_W      = 8;

    localparam int POS_W = 12;
    localparam int LEN_W = 13;

    localparam logic [CFG_SIZE_W-1:0] RST_CANVAS_WIDTH    = 13'd4096;
    localparam logic [CFG_SIZE_W-1:0] RST_CANVAS_HEIGHT   = 13'd4096;
    localparam logic [CHAN_W-1:0]     RST_WHITE_THRESHOLD = 8'd250;
    localparam logic [PAD_W-1:0]      RST_PAD_PIXELS      = 8'd20;

    // BT.601 luma in Q14, coefficients sum to 2^14
    localparam int GSUM_W     = 22;
    localparam int GRAY_SHIFT = 14;
    localparam logic [GSUM_W-1:0] GRAY_COEF_B = 22'd1868;
    localparam logic [GSUM_W-1:0] GRAY_COEF_G = 22'd9617;
    localparam logic [GSUM_W-1:0] GRAY_COEF_R = 22'd4899;
    localparam logic [GSUM_W-1:0] GRAY_ROUND  = 22'd8192;

endpackage

@@ hw/rtl/nwbb_track.sv @@
// ----------------------------------------------------------------------------
// nwbb_track
// Pixel input register, gray conversion, raster counters and the running
// min/max box. Emits the final box of a frame on its last pixel.
// ----------------------------------------------------------------------------
module nwbb_track #(
    parameter int CW  = 12,
    parameter int RW  = 12,
    parameter int SWW = 13,
    parameter int SWH = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [nwbb_pkg::CHAN_W-1:0] i_blue,
    input  logic [nwbb_pkg::CHAN_W-1:0] i_green,
    input  logic [nwbb_pkg::CHAN_W-1:0] i_red,
    input  logic [SWW-1:0]            i_width,
    input  logic [SWH-1:0]            i_height,
    input  logic [nwbb_pkg::CHAN_W-1:0] i_threshold,
    input  logic                      i_fin_free,
    output logic                      o_fin,
    output logic                      o_any,
    output logic [CW-1:0]             o_min_c,
    output logic [CW-1:0]             o_max_c,
    output logic [RW-1:0]             o_min_r,
    output logic [RW-1:0]             o_max_r
);
    import nwbb_pkg::*;

    localparam int LCW = CW + 1;
    localparam int LRW = RW + 1;

    logic              r_px_valid;
    logic [CHAN_W-1:0] r_blue, r_green, r_red;
    logic [CW-1:0]     r_col, r_min_c, r_max_c;
    logic [RW-1:0]     r_row, r_min_r, r_max_r;
    logic              r_any;

    logic [CW-1:0]     n_min_c, n_max_c;
    logic [RW-1:0]     n_min_r, n_max_r;
    logic              n_any;

    logic [GSUM_W-1:0] gsum;
    logic [CHAN_W-1:0] gray;
    logic              hit, last_col, frame_end, adv, load;

    always_comb begin
        gsum = GRAY_COEF_B * GSUM_W'(r_blue) + GRAY_COEF_G * GSUM_W'(r_green)
             + GRAY_COEF_R * GSUM_W'(r_red) + GRAY_ROUND;
        gray = CHAN_W'(gsum >> GRAY_SHIFT);
        hit  = (gray <= i_threshold);

        last_col  = (LCW'(r_col) + LCW'(1)) >= LCW'(i_width);
        frame_end = last_col && ((LRW'(r_row) + LRW'(1)) >= LRW'(i_height));

        n_any   = r_any | hit;
        n_min_c = (hit && r_col < r_min_c) ? r_col : r_min_c;
        n_max_c = (hit && r_col > r_max_c) ? r_col : r_max_c;
        n_min_r = (hit && r_row < r_min_r) ? r_row : r_min_r;
        n_max_r = (hit && r_row > r_max_r) ? r_row : r_max_r;

        // the frame's last pixel needs room in the box register downstream
        adv  = r_px_valid && (!frame_end || i_fin_free);
        load = !r_px_valid || adv;
    end

    assign o_stall = !load;
    assign o_fin   = adv && frame_end;
    assign o_any   = n_any;
    assign o_min_c = n_min_c;
    assign o_max_c = n_max_c;
    assign o_min_r = n_min_r;
    assign o_max_r = n_max_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_min_c    <= '1;
            r_max_c    <= '0;
            r_min_r    <= '1;
            r_max_r    <= '0;
            r_any      <= 1'b0;
        end else begin
            if (load) begin
                r_px_valid <= i_valid;
            end
            if (adv) begin
                if (frame_end) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_min_c <= '1;
                    r_max_c <= '0;
                    r_min_r <= '1;
                    r_max_r <= '0;
                    r_any   <= 1'b0;
                end else begin
                    r_min_c <= n_min_c;
                    r_max_c <= n_max_c;
                    r_min_r <= n_min_r;
                    r_max_r <= n_max_r;
                    r_any   <= n_any;
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
        end
    end

endmodule

@@ hw/rtl/nwbb_pad_axis.sv @@
// ----------------------------------------------------------------------------
// nwbb_pad_axis
// Pads one axis of the box: position clamped at zero, extent clamped to the
// room left between the position and the canvas edge.
// ----------------------------------------------------------------------------
module nwbb_pad_axis #(
    parameter int CW = 12,
    parameter int SW = 13
) (
    input  logic [CW-1:0]                 i_lo,
    input  logic [CW-1:0]                 i_hi,
    input  logic [SW-1:0]                 i_size,
    input  logic [nwbb_pkg::PAD_W-1:0]    i_pad,
    output logic [nwbb_pkg::POS_W-1:0]    o_pos,
    output logic [nwbb_pkg::LEN_W-1:0]    o_len
);
    import nwbb_pkg::*;

    localparam int AW = ((CW > SW) ? CW : SW) + 1;
    localparam int EW = ((AW > PAD_W + 1) ? AW : PAD_W + 1) + 1;

    logic [EW-1:0] lo_e, hi_e, size_e, pad_e, pos, room, ext, len;

    always_comb begin
        lo_e   = EW'(i_lo);
        hi_e   = EW'(i_hi);
        size_e = EW'(i_size);
        pad_e  = EW'(i_pad);
        pos    = (lo_e >= pad_e) ? lo_e - pad_e : '0;
        room   = (size_e > pos) ? size_e - pos : '0;
        // extent keeps both pads even when the left edge clamped at zero
        ext    = hi_e - lo_e + EW'(1) + (pad_e << 1);
        len    = (ext > room) ? room : ext;
    end

    assign o_pos = POS_W'(pos);
    assign o_len = LEN_W'(len);

endmodule

@@ hw/rtl/non_white_bounding_box_crop_top.sv @@
// ----------------------------------------------------------------------------
// non_white_bounding_box_crop_top
// Finds the bounding box of non-white pixels in a BGR raster frame and
// reports it padded and clamped to the canvas.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle when neither side stalls. Each
// pixel is converted to BT.601 gray and compared with white_threshold in the
// cycle after it is taken; the pixel that closes the frame produces one
// result through the input register, box register and output register,
// with found = 0 and a zero box if no pixel was non-white. Column
// and row are counted internally against canvas_width and canvas_height,
// where 0 counts as 1 and values above MAX_WIDTH / MAX_HEIGHT saturate.
// Registers sit at byte addresses 0, 4, 8, 12: canvas_width, canvas_height,
// white_threshold, pad_pixels; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module non_white_bounding_box_crop_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [nwbb_pkg::CHAN_W-1:0]     i_blue,
    input  logic [nwbb_pkg::CHAN_W-1:0]     i_green,
    input  logic [nwbb_pkg::CHAN_W-1:0]     i_red,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic [nwbb_pkg::POS_W-1:0]      o_box_x,
    output logic [nwbb_pkg::POS_W-1:0]      o_box_y,
    output logic [nwbb_pkg::LEN_W-1:0]      o_box_width,
    output logic [nwbb_pkg::LEN_W-1:0]      o_box_height,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nwbb_pkg::ADDR_W-1:0]     paddr,
    input  logic [nwbb_pkg::DATA_W-1:0]     pwdata,
    output logic [nwbb_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import nwbb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SWH = $clog2(MAX_HEIGHT + 1);
    localparam int ZWW = (SWW > CFG_SIZE_W) ? SWW : CFG_SIZE_W;
    localparam int ZWH = (SWH > CFG_SIZE_W) ? SWH : CFG_SIZE_W;

    // configuration registers
    logic [CFG_SIZE_W-1:0] r_canvas_width, r_canvas_height;
    logic [CHAN_W-1:0]     r_white_threshold;
    logic [PAD_W-1:0]      r_pad_pixels;
    t_reg_idx              reg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width    <= RST_CANVAS_WIDTH;
            r_canvas_height   <= RST_CANVAS_HEIGHT;
            r_white_threshold <= RST_WHITE_THRESHOLD;
            r_pad_pixels      <= RST_PAD_PIXELS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CANVAS_WIDTH:    r_canvas_width    <= pwdata[CFG_SIZE_W-1:0];
                REG_CANVAS_HEIGHT:   r_canvas_height   <= pwdata[CFG_SIZE_W-1:0];
                REG_WHITE_THRESHOLD: r_white_threshold <= pwdata[CHAN_W-1:0];
                REG_PAD_PIXELS:      r_pad_pixels      <= pwdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CANVAS_WIDTH:    prdata = DATA_W'(r_canvas_width);
            REG_CANVAS_HEIGHT:   prdata = DATA_W'(r_canvas_height);
            REG_WHITE_THRESHOLD: prdata = DATA_W'(r_white_threshold);
            REG_PAD_PIXELS:      prdata = DATA_W'(r_pad_pixels);
            default:             prdata = '0;
        endcase
    end

    // effective canvas size: zero counts as one, saturate at the maximum
    logic [ZWW-1:0] cw_ext;
    logic [ZWH-1:0] ch_ext;
    logic [SWW-1:0] eff_width;
    logic [SWH-1:0] eff_height;

    always_comb begin
        cw_ext = ZWW'(r_canvas_width);
        ch_ext = ZWH'(r_canvas_height);
        if (cw_ext == '0) begin
            eff_width = SWW'(1);
        end else if (cw_ext > ZWW'(MAX_WIDTH)) begin
            eff_width = SWW'(MAX_WIDTH);
        end else begin
            eff_width = SWW'(cw_ext);
        end
        if (ch_ext == '0) begin
            eff_height = SWH'(1);
        end else if (ch_ext > ZWH'(MAX_HEIGHT)) begin
            eff_height = SWH'(MAX_HEIGHT);
        end else begin
            eff_height = SWH'(ch_ext);
        end
    end

    // pixel tracking
    logic          fin, fin_any, fin_free, fin_move;
    logic [CW-1:0] fin_min_c, fin_max_c;
    logic [RW-1:0] fin_min_r, fin_max_r;

    nwbb_track #(
        .CW  (CW),
        .RW  (RW),
        .SWW (SWW),
        .SWH (SWH)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_threshold (r_white_threshold),
        .i_fin_free  (fin_free),
        .o_fin       (fin),
        .o_any       (fin_any),
        .o_min_c     (fin_min_c),
        .o_max_c     (fin_max_c),
        .o_min_r     (fin_min_r),
        .o_max_r     (fin_max_r)
    );

    // frame box register
    logic          r_fin_valid, r_fin_any;
    logic [CW-1:0] r_fin_min_c, r_fin_max_c;
    logic [RW-1:0] r_fin_min_r, r_fin_max_r;
    logic          r_out_valid;

    assign fin_move = r_fin_valid && (!r_out_valid || !i_stall);
    assign fin_free = !r_fin_valid || fin_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_fin_any   <= fin_any;
            r_fin_min_c <= fin_min_c;
            r_fin_max_c <= fin_max_c;
            r_fin_min_r <= fin_min_r;
            r_fin_max_r <= fin_max_r;
        end
    end

    // padding and clamping
    logic [POS_W-1:0] pad_x, pad_y;
    logic [LEN_W-1:0] pad_w, pad_h;

    nwbb_pad_axis #(
        .CW (CW),
        .SW (SWW)
    ) u_pad_x (
        .i_lo   (r_fin_min_c),
        .i_hi   (r_fin_max_c),
        .i_size (eff_width),
        .i_pad  (r_pad_pixels),
        .o_pos  (pad_x),
        .o_len  (pad_w)
    );

    nwbb_pad_axis #(
        .CW (RW),
        .SW (SWH)
    ) u_pad_y (
        .i_lo   (r_fin_min_r),
        .i_hi   (r_fin_max_r),
        .i_size (eff_height),
        .i_pad  (r_pad_pixels),
        .o_pos  (pad_y),
        .o_len  (pad_h)
    );

    // output register
    logic             r_found;
    logic [POS_W-1:0] r_box_x, r_box_y;
    logic [LEN_W-1:0] r_box_width, r_box_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            // an empty frame reports a zero box
            r_found      <= r_fin_any;
            r_box_x      <= r_fin_any ? pad_x : '0;
            r_box_y      <= r_fin_any ? pad_y : '0;
            r_box_width  <= r_fin_any ? pad_w : '0;
            r_box_height <= r_fin_any ? pad_h : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_found;
    assign o_box_x      = r_box_x;
    assign o_box_y      = r_box_y;
    assign o_box_width  = r_box_width;
    assign o_box_height = r_box_height;

endmodule
